FILE: hdl/cage_pkg.sv
package cage_pkg;

  localparam int MAX_COLUMNS_DEF   = 64;
  localparam int MAX_ROWS_DEF      = 64;
  localparam int STATE_COUNT_DEF   = 16;
  localparam int BITS_PER_WORD_DEF = 32;

  localparam logic [6:0]  GRID_COLUMNS_RST = 7'd64;
  localparam logic [6:0]  GRID_ROWS_RST    = 7'd64;
  localparam logic [3:0]  DIM_END_RST      = 4'd4;
  localparam logic [15:0] GEN_LIMIT_RST    = 16'd2400;
  localparam logic [15:0] GEN_MAX          = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS   = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_DIM_END   = 2'd2,
    CFG_GEN_LIMIT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_RENDER,
    ST_RWB,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] cell_index;
    logic [3:0]  cell_state;
    logic [6:0]  word_index;
  } in_t;

  typedef struct packed {
    logic [31:0] bright_word;
    logic [31:0] dim_word;
    logic [31:0] dirty_word;
    logic [15:0] generation_count;
    logic [12:0] changed_cells;
    logic        restart_needed;
    logic        full_redraw;
  } out_t;

endpackage

FILE: hdl/cyclic_automaton_grid_engine.sv
// Throughput: one item at a time; the single read port of the cell memory limits the
// pace, with nine reads per cell in a step and one read per cell in a render pass.
// Reset: synchronous, active high; planes read as zero through per-word valid bits,
// configuration returns to defaults, cell memory holds whatever it held until written.
module cyclic_automaton_grid_engine #(
  parameter int MAX_COLUMNS   = cage_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = cage_pkg::MAX_ROWS_DEF,
  parameter int STATE_COUNT   = cage_pkg::STATE_COUNT_DEF,
  parameter int BITS_PER_WORD = cage_pkg::BITS_PER_WORD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cage_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cage_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam int CELL_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int PLANE_DEPTH = (CELL_DEPTH + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int AW    = $clog2(CELL_DEPTH);
  localparam int CNT_W = $clog2(CELL_DEPTH + 1);
  localparam int XW    = $clog2(MAX_COLUMNS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);
  localparam int SW    = $clog2(STATE_COUNT);
  localparam int PWW   = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int BW    = $clog2(BITS_PER_WORD + 1);
  localparam int BIW   = $clog2(BITS_PER_WORD);
  localparam int RW    = CNT_W + 14;
  localparam int DW    = 3 * BITS_PER_WORD;
  localparam logic [3:0] NBR_LAST = 4'd9;

  // configuration
  logic [6:0]  grid_columns, grid_rows;
  logic [3:0]  dim_state_end;
  logic [15:0] generation_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns     <= cage_pkg::GRID_COLUMNS_RST;
      grid_rows        <= cage_pkg::GRID_ROWS_RST;
      dim_state_end    <= cage_pkg::DIM_END_RST;
      generation_limit <= cage_pkg::GEN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cage_pkg::cfg_index_t'(cfg_index))
        cage_pkg::CFG_COLUMNS:   grid_columns     <= cfg_data[6:0];
        cage_pkg::CFG_ROWS:      grid_rows        <= cfg_data[6:0];
        cage_pkg::CFG_DIM_END:   dim_state_end    <= cfg_data[3:0];
        cage_pkg::CFG_GEN_LIMIT: generation_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the grid to the storage and derive the cell count
  logic [XW-1:0]    cu;
  logic [YW-1:0]    ru;
  logic [CNT_W-1:0] cells;

  assign cu = ({2'b00, grid_columns} > 9'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS) : XW'(grid_columns);
  assign ru = ({2'b00, grid_rows} > 9'(MAX_ROWS)) ? YW'(MAX_ROWS) : YW'(grid_rows);
  assign cells = CNT_W'(CNT_W'(cu) * CNT_W'(ru));

  // sequencer and datapath registers
  cage_pkg::state_t state, state_next;
  logic             bank;
  logic [3:0]       k;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [AW-1:0]    cidx;
  logic [SW-1:0]    s_cur;
  logic             adv;
  logic [CNT_W-1:0] changed;
  logic [RW-1:0]    base;
  logic [BW-1:0]    b;
  logic [PWW-1:0]   word;
  logic [BITS_PER_WORD-1:0] br_acc, dm_acc;
  logic             start_mode;
  logic             is_read, rd_ok;
  logic [15:0]      generation;
  logic             redraw_flag;
  logic [CNT_W-1:0] changed_count;
  logic             restart_flag;

  // memories
  logic                 cell_we;
  logic [AW:0]          cell_waddr, cell_raddr;
  logic [SW-1:0]        cell_wdata, cell_rdata;
  logic                 plane_we, plane_re;
  logic [PWW-1:0]       plane_waddr, plane_raddr;
  logic [DW-1:0]        plane_wdata, plane_rdata;

  cage_cell_mem #(.AW(AW + 1), .SW(SW)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  cage_plane_mem #(.DEPTH(PLANE_DEPTH), .AW(PWW), .DW(DW)) u_planes (
    .clk   (clk),
    .rst   (rst),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (plane_wdata),
    .re    (plane_re),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

  // neighbor coordinates on the torus
  logic [XW-1:0] xm, xp, rx;
  logic [YW-1:0] ym, yp, ry;
  logic [SW-1:0] ns;
  logic          match, adv_fin;
  logic          last_x, last_y;
  logic [4:0]    wr_state;
  logic [15:0]   gen_inc;
  logic          accept;
  logic          bit_live;
  logic [BIW-1:0] bpos;
  logic [BITS_PER_WORD-1:0] old_br, old_dm, dirty_new;
  logic [63:0]   br_ext, dm_ext, dt_ext;
  cage_pkg::out_t result;

  assign xm = (x == '0) ? XW'(cu - 1'b1) : XW'(x - 1'b1);
  assign xp = (x == XW'(cu - 1'b1)) ? '0 : XW'(x + 1'b1);
  assign ym = (y == '0) ? YW'(ru - 1'b1) : YW'(y - 1'b1);
  assign yp = (y == YW'(ru - 1'b1)) ? '0 : YW'(y + 1'b1);
  assign last_x = (x == XW'(cu - 1'b1));
  assign last_y = (y == YW'(ru - 1'b1));

  assign ns      = (s_cur == SW'(STATE_COUNT - 1)) ? '0 : SW'(s_cur + 1'b1);
  assign match   = (k >= 4'd2) && (cell_rdata == ns);
  assign adv_fin = adv | match;
  assign gen_inc = (generation == cage_pkg::GEN_MAX) ? generation : generation + 16'd1;
  assign accept  = in_valid && in_ready;
  assign in_ready = (state == cage_pkg::ST_IDLE);

  assign bit_live = (b != '0) && ((RW'(base) + RW'(b) - RW'(1)) < RW'(cells));
  assign bpos     = BIW'(b - 1'b1);
  assign old_br   = plane_rdata[DW-1 -: BITS_PER_WORD];
  assign old_dm   = plane_rdata[DW-BITS_PER_WORD-1 -: BITS_PER_WORD];
  assign dirty_new = start_mode ? '0 : ((old_br ^ br_acc) | (old_dm ^ dm_acc));

  // reduce a written state modulo the state count
  always_comb begin
    wr_state = {1'b0, in_data.cell_state};
    for (int i = 0; i < 5; i++) begin
      if (wr_state >= 5'(STATE_COUNT)) begin
        wr_state = wr_state - 5'(STATE_COUNT);
      end
    end
  end

  // pick the coordinate for neighbor read k: self first, then the eight around it
  always_comb begin
    case (k)
      4'd1:    begin ry = ym; rx = xm; end
      4'd2:    begin ry = ym; rx = x;  end
      4'd3:    begin ry = ym; rx = xp; end
      4'd4:    begin ry = y;  rx = xm; end
      4'd5:    begin ry = y;  rx = xp; end
      4'd6:    begin ry = yp; rx = xm; end
      4'd7:    begin ry = yp; rx = x;  end
      4'd8:    begin ry = yp; rx = xp; end
      default: begin ry = y;  rx = x;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cage_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cell_we     = 1'b0;
    cell_waddr  = {bank, AW'(in_data.cell_index)};
    cell_wdata  = SW'(wr_state);
    cell_raddr  = {bank, AW'(CNT_W'(ry) * CNT_W'(cu) + CNT_W'(rx))};
    plane_we    = 1'b0;
    plane_waddr = word;
    plane_wdata = {br_acc, dm_acc, dirty_new};
    plane_re    = 1'b0;
    plane_raddr = word;
    case (state)
      cage_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            cage_pkg::KIND_WRITE: begin
              // drop writes outside the grid in use
              cell_we = ({{(RW-12){1'b0}}, in_data.cell_index} < RW'(cells));
              state_next = cage_pkg::ST_DONE;
            end
            cage_pkg::KIND_START: begin
              state_next = (cells == '0) ? cage_pkg::ST_DONE : cage_pkg::ST_RENDER;
            end
            cage_pkg::KIND_STEP: begin
              state_next = (cells == '0) ? cage_pkg::ST_DONE : cage_pkg::ST_CELL;
            end
            default: begin
              // fetch the plane word while the request payload is still valid
              plane_re    = 1'b1;
              plane_raddr = PWW'(in_data.word_index);
              state_next  = cage_pkg::ST_READ;
            end
          endcase
        end
      end
      cage_pkg::ST_CELL: begin
        // write the new state into the other bank after the last neighbor
        if (k == NBR_LAST) begin
          cell_we    = 1'b1;
          cell_waddr = {~bank, cidx};
          cell_wdata = adv_fin ? ns : s_cur;
          if (last_x && last_y) begin
            state_next = cage_pkg::ST_RENDER;
          end
        end
      end
      cage_pkg::ST_RENDER: begin
        cell_raddr = {bank, AW'(base + RW'(b))};
        plane_re   = (b == '0);
        if (b == BW'(BITS_PER_WORD)) begin
          state_next = cage_pkg::ST_RWB;
        end
      end
      cage_pkg::ST_RWB: begin
        plane_we = 1'b1;
        state_next = ((base + RW'(BITS_PER_WORD)) < RW'(cells)) ? cage_pkg::ST_RENDER
                                                                : cage_pkg::ST_DONE;
      end
      cage_pkg::ST_READ: begin
        // hold the plane word in the read register
        state_next = cage_pkg::ST_DONE;
      end
      cage_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          state_next = cage_pkg::ST_IDLE;
        end
      end
      default: state_next = cage_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bank          <= 1'b0;
      generation    <= '0;
      redraw_flag   <= 1'b1;
      changed_count <= '0;
      restart_flag  <= 1'b0;
      start_mode    <= 1'b0;
      is_read       <= 1'b0;
      rd_ok         <= 1'b0;
      k             <= '0;
      b             <= '0;
    end else begin
      case (state)
        cage_pkg::ST_IDLE: begin
          if (accept) begin
            is_read <= (in_data.kind == cage_pkg::KIND_READ);
            rd_ok   <= (RW'(in_data.word_index) * RW'(BITS_PER_WORD)) < RW'(cells);
            x       <= '0;
            y       <= '0;
            cidx    <= '0;
            k       <= '0;
            adv     <= 1'b0;
            changed <= '0;
            base    <= '0;
            b       <= '0;
            word    <= '0;
            br_acc  <= '0;
            dm_acc  <= '0;
            if (in_data.kind == cage_pkg::KIND_START) begin
              generation    <= '0;
              redraw_flag   <= 1'b1;
              changed_count <= '0;
              restart_flag  <= 1'b0;
              start_mode    <= 1'b1;
            end
          end
        end
        cage_pkg::ST_CELL: begin
          if (k == 4'd1) begin
            s_cur <= cell_rdata;
          end
          if (match) begin
            adv <= 1'b1;
          end
          if (k == NBR_LAST) begin
            k    <= '0;
            adv  <= 1'b0;
            cidx <= AW'(cidx + 1'b1);
            if (last_x) begin
              x <= '0;
              y <= YW'(y + 1'b1);
            end else begin
              x <= XW'(x + 1'b1);
            end
            if (last_x && last_y) begin
              // sweep done: swap banks and update the counters
              bank          <= ~bank;
              generation    <= gen_inc;
              redraw_flag   <= 1'b0;
              changed_count <= changed + CNT_W'(adv_fin);
              restart_flag  <= ((changed + CNT_W'(adv_fin)) == '0) ||
                               (gen_inc > generation_limit);
              start_mode    <= 1'b0;
            end else begin
              changed <= changed + CNT_W'(adv_fin);
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        cage_pkg::ST_RENDER: begin
          if (bit_live) begin
            br_acc[bpos] <= (cell_rdata == SW'(1));
            dm_acc[bpos] <= (4'(cell_rdata) >= 4'd2) && (4'(cell_rdata) <= dim_state_end);
          end
          b <= BW'(b + 1'b1);
        end
        cage_pkg::ST_RWB: begin
          br_acc <= '0;
          dm_acc <= '0;
          b      <= '0;
          base   <= base + RW'(BITS_PER_WORD);
          word   <= PWW'(word + 1'b1);
        end
        default: ;
      endcase
    end
  end

  // result assembly and output register
  assign br_ext = 64'(old_br);
  assign dm_ext = 64'(old_dm);
  assign dt_ext = 64'(plane_rdata[BITS_PER_WORD-1:0]);

  always_comb begin
    result.bright_word      = (is_read && rd_ok) ? br_ext[31:0] : '0;
    result.dim_word         = (is_read && rd_ok) ? dm_ext[31:0] : '0;
    result.dirty_word       = (is_read && rd_ok) ? dt_ext[31:0] : '0;
    result.generation_count = generation;
    result.changed_cells    = 13'(changed_count);
    result.restart_needed   = restart_flag;
    result.full_redraw      = redraw_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cage_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cage_pkg::ST_DONE && (!out_valid || out_ready)) begin
      out_data <= result;
    end
  end

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a render pass only runs on a nonempty grid
  a_render_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == cage_pkg::ST_RENDER) |-> (cells != '0))
    else $error("render pass on an empty grid");

  // a new result comes only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == cage_pkg::ST_DONE))
    else $error("result raised outside the done state");

endmodule

FILE: hdl/cage_cell_mem.sv
module cage_cell_mem #(
  parameter int AW = 13,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [SW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [SW-1:0] rdata
);

  logic [SW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cage_plane_mem.sv
module cage_plane_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0]    mem_q;
  logic             valid_q;

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        valid_q <= valid[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule
